>>> design/mbsd_pkg.sv
package mbsd_pkg;

    // Fixed field, history and bus widths
    localparam int FIELD_W = 8;
    localparam int HIST_W  = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Register indexes (byte address 4*i)
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_LOW_SENSE = 2'd1;
    localparam logic [1:0] REG_PATTERN   = 2'd2;

    // History patterns and solid reload values
    localparam logic [HIST_W-1:0] PAT_HI     = 8'hC0;
    localparam logic [HIST_W-1:0] PAT_LO     = 8'h07;
    localparam logic [HIST_W-1:0] SOLID_HIGH = 8'hFF;
    localparam logic [HIST_W-1:0] SOLID_LOW  = 8'h00;
    localparam logic [HIST_W-1:0] PAT_MASK_RST = 8'hC7;

    // Current configuration
    typedef struct packed {
        logic [FIELD_W-1:0] enable;
        logic [FIELD_W-1:0] low_sense;
        logic [FIELD_W-1:0] pattern;
    } t_cfg;

    // Side effects of a configuration write
    typedef struct packed {
        logic               reload;
        logic [FIELD_W-1:0] fresh;
        logic [FIELD_W-1:0] reload_low;
    } t_cfg_wr;

    // Per-lane control bits
    typedef struct packed {
        logic step;
        logic enable;
        logic low_sense;
        logic reload;
        logic reload_low;
        logic fresh;
    } t_lane_ctl;

    // Per-lane findings
    typedef struct packed {
        logic press;
        logic release_ev;
        logic held;
    } t_lane_evt;

endpackage

>>> design/mbsd_if.sv
interface mbsd_in_if import mbsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] raw_levels;
    logic [FIELD_W-1:0] ack_pressed;
    logic [FIELD_W-1:0] ack_released;

    modport source (output valid, output raw_levels, output ack_pressed,
                    output ack_released, input ready);
    modport sink   (input valid, input raw_levels, input ack_pressed,
                    input ack_released, output ready);
endinterface

interface mbsd_out_if import mbsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] held_now;
    logic [FIELD_W-1:0] pressed_pending;
    logic [FIELD_W-1:0] released_pending;

    modport source (output valid, output held_now, output pressed_pending,
                    output released_pending, input ready);
    modport sink   (input valid, input held_now, input pressed_pending,
                    input released_pending, output ready);
endinterface

>>> design/mbsd_cfg.sv
module mbsd_cfg import mbsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output t_cfg              o_cfg,
    output t_cfg_wr           o_wr
);

    logic [FIELD_W-1:0] r_enable, n_enable;
    logic [FIELD_W-1:0] r_low_sense, n_low_sense;
    logic [FIELD_W-1:0] r_pattern, n_pattern;
    logic [1:0]         w_idx;
    logic [FIELD_W-1:0] w_val;
    logic               w_wr;

    assign w_idx = paddr[3:2];
    assign w_val = pwdata[FIELD_W-1:0];
    assign w_wr  = psel & penable & pwrite;

    // Register writes and their side effects
    always_comb begin
        n_enable        = r_enable;
        n_low_sense     = r_low_sense;
        n_pattern       = r_pattern;
        o_wr.reload     = 1'b0;
        o_wr.fresh      = '0;
        if (w_wr) begin
            case (w_idx)
                REG_ENABLE: begin
                    n_enable    = w_val;
                    o_wr.fresh  = w_val & ~r_enable;
                    o_wr.reload = 1'b1;
                end
                REG_LOW_SENSE: begin
                    n_low_sense = w_val;
                    o_wr.reload = 1'b1;
                end
                REG_PATTERN: begin
                    n_pattern   = w_val;
                    o_wr.reload = 1'b1;
                end
                default: ;
            endcase
        end
        o_wr.reload_low = n_low_sense;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= '0;
            r_low_sense <= '0;
            r_pattern   <= PAT_MASK_RST;
        end else begin
            r_enable    <= n_enable;
            r_low_sense <= n_low_sense;
            r_pattern   <= n_pattern;
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_ENABLE:    prdata[FIELD_W-1:0] = r_enable;
            REG_LOW_SENSE: prdata[FIELD_W-1:0] = r_low_sense;
            REG_PATTERN:   prdata[FIELD_W-1:0] = r_pattern;
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.enable    = r_enable;
    assign o_cfg.low_sense = r_low_sense;
    assign o_cfg.pattern   = r_pattern;

endmodule

>>> design/mbsd_lane.sv
module mbsd_lane import mbsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic [HIST_W-1:0] i_pattern,
    input  logic              i_raw,
    output t_lane_evt         o_evt
);

    logic [HIST_W-1:0] r_hist, n_hist;
    logic              r_held, n_held;
    logic [HIST_W-1:0] w_shift, w_masked, w_press_pat, w_rel_pat;

    assign w_shift     = {r_hist[HIST_W-2:0], i_raw};
    assign w_masked    = w_shift & i_pattern;
    assign w_press_pat = i_ctl.low_sense ? PAT_HI : PAT_LO;
    assign w_rel_pat   = i_ctl.low_sense ? PAT_LO : PAT_HI;

    // Shift, compare and hysteresis reload
    always_comb begin
        n_hist           = r_hist;
        n_held           = r_held;
        o_evt.press      = 1'b0;
        o_evt.release_ev = 1'b0;
        if (i_ctl.reload) begin
            n_hist = i_ctl.reload_low ? SOLID_HIGH : SOLID_LOW;
            if (i_ctl.fresh) begin
                n_held = 1'b0;
            end
        end else if (i_ctl.step && i_ctl.enable) begin
            n_hist = w_shift;
            if (w_masked == w_press_pat && !r_held) begin
                n_held      = 1'b1;
                o_evt.press = 1'b1;
                n_hist      = i_ctl.low_sense ? SOLID_LOW : SOLID_HIGH;
            end else if (w_masked == w_rel_pat && r_held) begin
                n_held           = 1'b0;
                o_evt.release_ev = 1'b1;
                n_hist           = i_ctl.low_sense ? SOLID_HIGH : SOLID_LOW;
            end
        end
        o_evt.held = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= SOLID_LOW;
            r_held <= 1'b0;
        end else begin
            r_hist <= n_hist;
            r_held <= n_held;
        end
    end

endmodule

>>> design/mbsd_merge.sv
module mbsd_merge import mbsd_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_lane_evt          i_evt [LANES],
    input  logic [FIELD_W-1:0] i_ack_pressed,
    input  logic [FIELD_W-1:0] i_ack_released,
    input  logic [FIELD_W-1:0] i_fresh,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_held_now,
    output logic [FIELD_W-1:0] o_pressed_pending,
    output logic [FIELD_W-1:0] o_released_pending
);

    logic [LANES-1:0]   r_pressed, n_pressed;
    logic [LANES-1:0]   r_released, n_released;
    logic [LANES-1:0]   w_press, w_rel, w_held;
    logic [FIELD_W-1:0] w_held_full, w_press_full, w_rel_full;
    logic               r_valid;
    logic [FIELD_W-1:0] r_held_out, r_press_out, r_rel_out;

    // Gather lane findings
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_press[i] = i_evt[i].press;
            w_rel[i]   = i_evt[i].release_ev;
            w_held[i]  = i_evt[i].held;
        end
    end

    // On a step, acknowledges clear first and new events set afterwards; else fresh lanes clear
    always_comb begin
        n_pressed  = r_pressed;
        n_released = r_released;
        if (i_step) begin
            n_pressed  = (r_pressed & ~i_ack_pressed[LANES-1:0]) | w_press;
            n_released = (r_released & ~i_ack_released[LANES-1:0]) | w_rel;
        end else begin
            n_pressed  = r_pressed & ~i_fresh[LANES-1:0];
            n_released = r_released & ~i_fresh[LANES-1:0];
        end
    end

    // Unused lanes read as zero
    always_comb begin
        w_held_full  = '0;
        w_press_full = '0;
        w_rel_full   = '0;
        w_held_full[LANES-1:0]  = w_held;
        w_press_full[LANES-1:0] = n_pressed;
        w_rel_full[LANES-1:0]   = n_released;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed  <= '0;
            r_released <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_pressed  <= n_pressed;
            r_released <= n_released;
            if (i_step) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_held_out  <= w_held_full;
            r_press_out <= w_press_full;
            r_rel_out   <= w_rel_full;
        end
    end

    assign o_in_ready         = ~r_valid | i_out_ready;
    assign o_out_valid        = r_valid;
    assign o_held_now         = r_held_out;
    assign o_pressed_pending  = r_press_out;
    assign o_released_pending = r_rel_out;

endmodule

>>> design/multi_button_shift_debouncer.sv
// The result of an accepted sample transaction is registered in the result register.
// Throughput: one sample per cycle while results are taken; each lane's shift and compare
// is one stage, and the result register takes a new result when empty or the old one is taken.
// Reset (synchronous, active low): histories and held/pending flags clear,
// lanes disabled, all lanes active-high, pattern mask 0xC7, no result pending.
module multi_button_shift_debouncer import mbsd_pkg::*; #(
    parameter int BUTTONS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbsd_in_if.sink           i_in_if,
    mbsd_out_if.source        o_out_if,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int LANES = (BUTTONS < FIELD_W) ? BUTTONS : FIELD_W;
    localparam logic [FIELD_W-1:0] LANE_MASK = FIELD_W'((1 << LANES) - 1);

    t_cfg      w_cfg;
    t_cfg_wr   w_wr;
    t_lane_evt w_evt [LANES];
    logic      w_step;
    logic      w_in_ready;

    assign pready         = 1'b1;
    assign w_step         = i_in_if.valid & w_in_ready;
    assign i_in_if.ready  = w_in_ready;

    // Configuration registers
    mbsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg),
        .o_wr    (w_wr)
    );

    // One debounce lane per button, at most FIELD_W lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        t_lane_ctl w_ctl;
        assign w_ctl.step       = w_step;
        assign w_ctl.enable     = w_cfg.enable[g];
        assign w_ctl.low_sense  = w_cfg.low_sense[g];
        assign w_ctl.reload     = w_wr.reload;
        assign w_ctl.reload_low = w_wr.reload_low[g];
        assign w_ctl.fresh      = w_wr.fresh[g];

        mbsd_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_pattern (w_cfg.pattern),
            .i_raw     (i_in_if.raw_levels[g]),
            .o_evt     (w_evt[g])
        );
    end

    // Flag merge and result register
    mbsd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_step),
        .i_evt              (w_evt),
        .i_ack_pressed      (i_in_if.ack_pressed),
        .i_ack_released     (i_in_if.ack_released),
        .i_fresh            (w_wr.fresh),
        .i_out_ready        (o_out_if.ready),
        .o_in_ready         (w_in_ready),
        .o_out_valid        (o_out_if.valid),
        .o_held_now         (o_out_if.held_now),
        .o_pressed_pending  (o_out_if.pressed_pending),
        .o_released_pending (o_out_if.released_pending)
    );

    // Checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_if.valid)
        else $error("accepted sample produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_step && o_out_if.valid && !o_out_if.ready))
        else $error("sample accepted over an untaken result");

    a_unused_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_if.valid |-> (((o_out_if.held_now | o_out_if.pressed_pending
            | o_out_if.released_pending) & ~LANE_MASK) == '0))
        else $error("unused lane reported activity");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import mbsd_pkg::*; ();

    localparam int LANES        = 8;
    localparam int REG_UNMAPPED = 3;        // first index past the register map
    localparam int RANDOM_TICKS = 1630;
    localparam int LONG_HOLD    = 120;      // receiver back-pressure stretch, cycles
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [FIELD_W-1:0] held;
        logic [FIELD_W-1:0] pressed;
        logic [FIELD_W-1:0] released;
    } t_flags;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        int                 reg_idx;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] raw;
        logic [FIELD_W-1:0] ack_p;
        logic [FIELD_W-1:0] ack_r;
        bit                 known;
        t_flags             want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mbsd_in_if  sample_if ();
    mbsd_out_if flags_if ();

    multi_button_shift_debouncer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_if  (sample_if),
        .o_out_if (flags_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Debouncer state as the block should hold it
    logic [FIELD_W-1:0] cfg_enable;
    logic [FIELD_W-1:0] cfg_low_sense;
    logic [FIELD_W-1:0] cfg_pattern;
    logic [HIST_W-1:0]  lane_hist [LANES];
    t_flags             lane_flags;

    t_flags expected_flags_q [$];
    t_row   directed_rows [$];

    int fault_cnt;
    int ticks_sent;
    int results_seen;
    int writes_done;
    int presses_seen;
    int releases_seen;

    // Handshake pacing
    bit          src_idles;
    bit          sink_idles;
    int          hold_req_cnt;
    int          hold_req_seen;
    int unsigned stall_left;

    // Bouncy pin generator state
    logic [FIELD_W-1:0] pin_level;
    int unsigned        pin_run [LANES];

    // --- expected behaviour ---

    function automatic void reload_histories();
        for (int i = 0; i < LANES; i++)
            lane_hist[i] = cfg_low_sense[i] ? SOLID_HIGH : SOLID_LOW;
    endfunction

    function automatic void reset_debouncer();
        cfg_enable    = '0;
        cfg_low_sense = '0;
        cfg_pattern   = PAT_MASK_RST;
        lane_flags    = '0;
        reload_histories();
    endfunction

    function automatic void apply_reg_write(input int idx, input logic [DATA_W-1:0] word);
        logic [FIELD_W-1:0] v;
        logic [FIELD_W-1:0] fresh;
        v = word[FIELD_W-1:0];
        case (idx)
            REG_ENABLE: begin
                // lanes coming out of disable start clean
                fresh               = v & ~cfg_enable;
                cfg_enable          = v;
                lane_flags.held     &= ~fresh;
                lane_flags.pressed  &= ~fresh;
                lane_flags.released &= ~fresh;
            end
            REG_LOW_SENSE: cfg_low_sense = v;
            REG_PATTERN:   cfg_pattern = v;
            default:       return;
        endcase
        reload_histories();
    endfunction

    function automatic t_flags debounce_tick(input logic [FIELD_W-1:0] raw,
                                             input logic [FIELD_W-1:0] ack_p,
                                             input logic [FIELD_W-1:0] ack_r);
        logic [HIST_W-1:0]  hist;
        logic [HIST_W-1:0]  masked;
        logic [HIST_W-1:0]  press_pat;
        logic [HIST_W-1:0]  release_pat;
        logic [FIELD_W-1:0] new_press;
        logic [FIELD_W-1:0] new_release;
        logic               is_low;
        new_press   = '0;
        new_release = '0;
        for (int i = 0; i < LANES; i++) begin
            if (!cfg_enable[i])
                continue;
            is_low      = cfg_low_sense[i];
            press_pat   = is_low ? PAT_HI : PAT_LO;
            release_pat = is_low ? PAT_LO : PAT_HI;
            hist        = {lane_hist[i][HIST_W-2:0], raw[i]};
            masked      = hist & cfg_pattern;
            if (masked == press_pat && !lane_flags.held[i]) begin
                lane_flags.held[i] = 1'b1;
                new_press[i]       = 1'b1;
                hist               = is_low ? SOLID_LOW : SOLID_HIGH;
            end else if (masked == release_pat && lane_flags.held[i]) begin
                lane_flags.held[i] = 1'b0;
                new_release[i]     = 1'b1;
                hist               = is_low ? SOLID_HIGH : SOLID_LOW;
            end
            lane_hist[i] = hist;
        end
        // acknowledges first, then this tick's events
        lane_flags.pressed  = (lane_flags.pressed & ~ack_p) | new_press;
        lane_flags.released = (lane_flags.released & ~ack_r) | new_release;
        presses_seen  += $countones(new_press);
        releases_seen += $countones(new_release);
        return lane_flags;
    endfunction

    // --- stimulus helpers ---

    function automatic t_row tick_row(input logic [FIELD_W-1:0] raw,
                                      input logic [FIELD_W-1:0] ack_p,
                                      input logic [FIELD_W-1:0] ack_r);
        t_row r;
        r       = '{kind: ROW_TICK, default: '0};
        r.raw   = raw;
        r.ack_p = ack_p;
        r.ack_r = ack_r;
        return r;
    endfunction

    function automatic t_row known_row(input logic [FIELD_W-1:0] raw,
                                       input logic [FIELD_W-1:0] ack_p,
                                       input logic [FIELD_W-1:0] ack_r,
                                       input logic [FIELD_W-1:0] held,
                                       input logic [FIELD_W-1:0] pressed,
                                       input logic [FIELD_W-1:0] released);
        t_row r;
        r       = tick_row(raw, ack_p, ack_r);
        r.known = 1'b1;
        r.want  = {held, pressed, released};
        return r;
    endfunction

    function automatic t_row write_row(input int idx, input logic [FIELD_W-1:0] value);
        t_row r;
        r         = '{kind: ROW_WRITE, default: '0};
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // pins that hold a level for a run of ticks, with the odd one-tick glitch, or random levels when noisy
    function automatic logic [FIELD_W-1:0] bouncy_levels(input bit noisy);
        logic [FIELD_W-1:0] lv;
        if (noisy)
            return FIELD_W'($urandom);
        for (int i = 0; i < LANES; i++) begin
            if (pin_run[i] == 0) begin
                pin_level[i] = ~pin_level[i];
                pin_run[i]   = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                           : $urandom_range(1, 9);
            end
            pin_run[i]--;
        end
        lv = pin_level;
        if ($urandom_range(0, 19) == 0)
            lv[$urandom_range(0, LANES - 1)] ^= 1'b1;
        return lv;
    endfunction

    function automatic logic [FIELD_W-1:0] ack_pick(input logic [FIELD_W-1:0] pending);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return FIELD_W'($urandom);
            7, 8:       return pending;
            default:    return '1;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] mask_pick();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3, 4: return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // All driving tasks start and end just after a rising edge
    task automatic push_tick(input logic [FIELD_W-1:0] raw,
                             input logic [FIELD_W-1:0] ack_p,
                             input logic [FIELD_W-1:0] ack_r,
                             input bit known, input t_flags want);
        t_flags predicted;
        sample_if.valid        <= 1'b1;
        sample_if.raw_levels   <= raw;
        sample_if.ack_pressed  <= ack_p;
        sample_if.ack_released <= ack_r;
        do @(posedge i_clk); while (sample_if.ready !== 1'b1);
        predicted = debounce_tick(raw, ack_p, ack_r);
        expected_flags_q.push_back(known ? want : predicted);
        ticks_sent++;
    endtask

    task automatic sender_gap();
        if (src_idles && $urandom_range(0, 2) == 0) begin
            sample_if.valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    // hold the sample side off until every expected result has come back
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_flags_q.size() != 0);
    endtask

    task automatic reg_write(input int idx, input logic [FIELD_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = {{(DATA_W-FIELD_W){1'b0}}, value};
        if ($urandom_range(0, 3) == 0)
            word[DATA_W-1:FIELD_W] = (DATA_W-FIELD_W)'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        apply_reg_write(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        writes_done++;
    endtask

    function automatic void check_field(input string name,
                                        input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
            fault_cnt++;
        end
    endfunction

    // Receiver: random stalls plus an occasional long hold on request
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_req_seen) begin
            hold_req_seen = hold_req_cnt;
            stall_left    = LONG_HOLD;
        end
        if (stall_left != 0) begin
            stall_left--;
            flags_if.ready <= 1'b0;
        end else if (sink_idles && $urandom_range(0, 3) == 0) begin
            stall_left     = idle_len() - 1;
            flags_if.ready <= 1'b0;
        end else begin
            flags_if.ready <= 1'b1;
        end
    end

    // Result checking against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_flags want;
        if (i_rst_n === 1'b1 && flags_if.valid === 1'b1 && flags_if.ready === 1'b1) begin
            results_seen++;
            if (expected_flags_q.size() == 0) begin
                $display("%0t: result %02h/%02h/%02h with nothing expected", $time,
                         flags_if.held_now, flags_if.pressed_pending,
                         flags_if.released_pending);
                fault_cnt++;
            end else begin
                want = expected_flags_q.pop_front();
                check_field("held_now", want.held, flags_if.held_now);
                check_field("pressed_pending", want.pressed, flags_if.pressed_pending);
                check_field("released_pending", want.released, flags_if.released_pending);
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        int          phase;
        int unsigned burst;
        int unsigned wait_cnt;
        bit          noisy;
        logic [FIELD_W-1:0] ack_p;
        logic [FIELD_W-1:0] ack_r;

        sample_if.valid        = 1'b0;
        sample_if.raw_levels   = '0;
        sample_if.ack_pressed  = '0;
        sample_if.ack_released = '0;
        flags_if.ready         = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        src_idles  = 1'b1;
        sink_idles = 1'b1;
        pin_level  = '0;
        foreach (pin_run[i])
            pin_run[i] = 0;
        reset_debouncer();

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: polarity mix, ack ordering, disable/enable, odd pattern masks
        directed_rows = '{
            known_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
            known_row(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00),
            write_row(REG_ENABLE, 8'hFF),
            write_row(REG_LOW_SENSE, 8'hF0),
            write_row(REG_PATTERN, PAT_MASK_RST),
            tick_row (8'h0F, 8'h00, 8'h00),
            tick_row (8'h0F, 8'h00, 8'h00),
            known_row(8'h0F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00),
            known_row(8'h0F, 8'h0F, 8'h00, 8'hFF, 8'hF0, 8'h00),
            tick_row (8'hF0, 8'h00, 8'h00),
            tick_row (8'hF0, 8'h00, 8'h00),
            known_row(8'hF0, 8'hF0, 8'hFF, 8'h00, 8'h00, 8'hFF),
            known_row(8'hF0, 8'h00, 8'h55, 8'h00, 8'h00, 8'hAA),
            tick_row (8'h0F, 8'h00, 8'h00),
            tick_row (8'h0F, 8'h00, 8'h00),
            // ack and new press in the same tick: the press survives
            known_row(8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00),
            write_row(REG_ENABLE, 8'h0F),
            tick_row (8'h00, 8'hF0, 8'h00),
            write_row(REG_ENABLE, 8'hFF),
            tick_row (8'h00, 8'h00, 8'h00),
            write_row(REG_LOW_SENSE, 8'h00),
            write_row(REG_PATTERN, 8'h07),
            tick_row (8'hFF, 8'h00, 8'h00),
            tick_row (8'hFF, 8'h00, 8'h00),
            tick_row (8'hFF, 8'h00, 8'h00),
            write_row(REG_PATTERN, 8'h00),
            tick_row (8'h55, 8'h00, 8'h00),
            tick_row (8'hAA, 8'h00, 8'h00),
            write_row(REG_UNMAPPED, 8'hFF),
            tick_row (8'h00, 8'h00, 8'h00),
            write_row(REG_PATTERN, 8'hFF),
            write_row(REG_LOW_SENSE, 8'hFF),
            tick_row (8'hFF, 8'hFF, 8'hFF),
            tick_row (8'h00, 8'h00, 8'h00)
        };
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                drain_results();
                reg_write(directed_rows[k].reg_idx, directed_rows[k].value);
            end else begin
                push_tick(directed_rows[k].raw, directed_rows[k].ack_p,
                          directed_rows[k].ack_r, directed_rows[k].known,
                          directed_rows[k].want);
                sender_gap();
            end
        end

        // Random phases, each under a possibly new configuration
        phase = 0;
        while (ticks_sent < RANDOM_TICKS + directed_rows.size()) begin
            drain_results();
            if ($urandom_range(0, 9) < 7)
                reg_write(REG_ENABLE, ($urandom_range(0, 9) < 6) ? 8'hFF : mask_pick());
            if ($urandom_range(0, 9) < 7)
                reg_write(REG_LOW_SENSE, mask_pick());
            if ($urandom_range(0, 9) < 5)
                reg_write(REG_PATTERN, ($urandom_range(0, 9) < 6) ? PAT_MASK_RST
                                                                  : mask_pick());
            if ($urandom_range(0, 9) == 0)
                reg_write(REG_UNMAPPED, FIELD_W'($urandom));

            noisy      = ($urandom_range(0, 6) == 0);
            src_idles  = (phase % 5 != 1);
            sink_idles = (phase % 5 != 3);
            burst      = $urandom_range(60, 140);

            // back-pressure phase: receiver holds off while items keep coming
            if (phase == 2) begin
                src_idles = 1'b0;
                hold_req_cnt++;
            end

            for (int unsigned j = 0;
                 j < burst && ticks_sent < RANDOM_TICKS + directed_rows.size(); j++) begin
                if (phase == 4 && j == burst / 2)
                    drain_results();
                ack_p = ack_pick(lane_flags.pressed);
                ack_r = ack_pick(lane_flags.released);
                push_tick(bouncy_levels(noisy), ack_p, ack_r, 1'b0, '0);
                sender_gap();
            end
            phase++;
        end

        // Wind down
        sample_if.valid <= 1'b0;
        wait_cnt = 0;
        while (expected_flags_q.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_flags_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_flags_q.size());
            fault_cnt++;
        end

        $display("run: %0d sample transactions over %0d phases, %0d register writes",
                 ticks_sent, phase, writes_done);
        $display("run: %0d results checked, %0d presses and %0d releases debounced",
                 results_seen, presses_seen, releases_seen);
        if (fault_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

>>> multi_button_shift_debouncer.f
design/mbsd_pkg.sv
design/mbsd_if.sv
design/mbsd_cfg.sv
design/mbsd_lane.sv
design/mbsd_merge.sv
design/multi_button_shift_debouncer.sv
tb/tb_top.sv
